### rtl/png_scanline_unfilter_macros.svh
// ----------------------------------------------------------------------------
// PNG scanline unfilter assertion macros
// Concurrent assertion wrappers used by the top level, which checks the block.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define PNGSU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pngsu: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define PNGSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pngsu: assertion failed");
`else
`define PNGSU_ASSERT(lbl, clk, rstn, prop)
`define PNGSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/pngsu_pkg.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Sizes, codes and the types passed between the unfilter modules.
// ----------------------------------------------------------------------------
package pngsu_pkg;

  localparam int ROW_MAX         = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int ROW_AW    = $clog2(ROW_MAX);
  localparam int LEN_W     = 14;
  localparam int PB_W      = 4;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;
  localparam int CALC_W    = ((ROW_AW > LEN_W) ? ROW_AW : LEN_W) + 1;
  localparam int HIST_AW   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int SLOT_W    = PB_W + 1;

  // Column modulo the history depth is taken by a reciprocal multiply.
  localparam int DIV_K     = ROW_AW + 4;
  localparam int DIV_RECIP = (2 ** DIV_K + MAX_PIXEL_BYTES - 1) / MAX_PIXEL_BYTES;
  localparam int DIV_RW    = DIV_K + 1;
  localparam int PROD_W    = ROW_AW + DIV_RW;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH  = CFG_IDX_W'(0),
    REG_PIXEL_BYTES = CFG_IDX_W'(1)
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       start_pass;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } out_item_t;

  // One result item on its way from the front end to the reconstruction.
  typedef struct packed {
    logic              err;
    logic [7:0]        fbyte;
    logic [ROW_AW-1:0] col;
    logic [ROW_AW-1:0] quo;
    filt_e             kind;
    logic              first_row;
    logic              last;
    logic [PB_W-1:0]   bpp;
  } stage_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

endpackage

### rtl/pngsu_if.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter stream interfaces
// Valid/ready channels for the raw byte stream and the reconstructed bytes.
// ----------------------------------------------------------------------------
interface pngsu_in_if;
  logic                valid;
  logic                ready;
  pngsu_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pngsu_out_if;
  logic                 valid;
  logic                 ready;
  pngsu_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/pngsu_row_mem.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter prior row memory
// One write port and one registered read port holding the previous scanline.
// ----------------------------------------------------------------------------
module pngsu_row_mem (
  input  logic               clk_i,
  input  pngsu_pkg::mem_wr_t wr_i,
  input  pngsu_pkg::mem_rd_t rd_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [pngsu_pkg::ROW_MAX];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pngsu_ctrl.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter front end
// Configuration registers, row sequencing and the stage register per item.
// ----------------------------------------------------------------------------
module pngsu_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pngsu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pngsu_pkg::CFG_W-1:0]         cfg_data_i,
  pngsu_in_if.sink                            in_i,
  input  logic                                s1_take_i,
  output logic                                stage_vld_o,
  output pngsu_pkg::stage_t                   stage_o,
  output pngsu_pkg::mem_rd_t                  rd_o
);

  logic [pngsu_pkg::LEN_W-1:0]  row_length_q;
  logic [pngsu_pkg::PB_W-1:0]   pixel_bytes_q;

  logic                          awaiting_q, awaiting_d;
  logic                          first_row_q, first_row_d;
  logic                          err_hold_q, err_hold_d;
  logic [pngsu_pkg::ROW_AW-1:0]  col_cnt_q, col_cnt_d;
  pngsu_pkg::filt_e              kind_q, kind_d;

  logic                          stage_vld_q;
  pngsu_pkg::stage_t             stage_q;

  logic                          acc;
  logic                          start;
  logic [pngsu_pkg::ROW_AW-1:0]  cc_eff;
  logic [pngsu_pkg::CALC_W-1:0]  len_w, col_w, col_inc;
  logic [pngsu_pkg::PB_W-1:0]    bpp;
  logic [pngsu_pkg::ROW_AW-1:0]  col;
  logic                          last;
  logic [pngsu_pkg::PROD_W-1:0]  prod;
  logic                          res_err, res_data;

  assign in_i.ready = !stage_vld_q || s1_take_i;
  assign acc        = in_i.valid && in_i.ready;
  assign start      = in_i.data.start_pass;

  always_comb begin
    len_w = pngsu_pkg::CALC_W'(row_length_q);
    if (len_w == '0) begin
      len_w = pngsu_pkg::CALC_W'(1);
    end else if (len_w > pngsu_pkg::CALC_W'(pngsu_pkg::ROW_MAX)) begin
      len_w = pngsu_pkg::CALC_W'(pngsu_pkg::ROW_MAX);
    end

    bpp = pixel_bytes_q;
    if (bpp == '0) begin
      bpp = pngsu_pkg::PB_W'(1);
    end else if (bpp > pngsu_pkg::PB_W'(pngsu_pkg::MAX_PIXEL_BYTES)) begin
      bpp = pngsu_pkg::PB_W'(pngsu_pkg::MAX_PIXEL_BYTES);
    end

    // A pass start abandons whatever row was in progress.
    cc_eff      = start ? '0 : col_cnt_q;
    awaiting_d  = start || awaiting_q;
    first_row_d = start || first_row_q;
    err_hold_d  = !start && err_hold_q;
    col_cnt_d   = cc_eff;
    kind_d      = kind_q;

    // A row shortened in mid-flight ends on its new last column.
    col_w = pngsu_pkg::CALC_W'(cc_eff);
    if (col_w >= len_w) begin
      col_w = len_w - pngsu_pkg::CALC_W'(1);
    end
    col     = col_w[pngsu_pkg::ROW_AW-1:0];
    col_inc = col_w + pngsu_pkg::CALC_W'(1);
    last    = col_inc >= len_w;

    prod = pngsu_pkg::PROD_W'(col) * pngsu_pkg::PROD_W'(pngsu_pkg::DIV_RECIP);

    res_err  = 1'b0;
    res_data = 1'b0;
    if (!err_hold_d) begin
      if (awaiting_d) begin
        if (in_i.data.stream_byte > 8'(pngsu_pkg::FILT_PAETH)) begin
          err_hold_d = 1'b1;
          res_err    = 1'b1;
        end else begin
          kind_d     = pngsu_pkg::filt_e'(in_i.data.stream_byte[2:0]);
          awaiting_d = 1'b0;
          col_cnt_d  = '0;
        end
      end else begin
        res_data = 1'b1;
        if (last) begin
          awaiting_d  = 1'b1;
          first_row_d = 1'b0;
          col_cnt_d   = '0;
        end else begin
          col_cnt_d = col_inc[pngsu_pkg::ROW_AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  <= pngsu_pkg::LEN_W'(1);
      pixel_bytes_q <= pngsu_pkg::PB_W'(1);
    end else if (cfg_we_i) begin
      unique case (pngsu_pkg::cfg_idx_e'(cfg_idx_i))
        pngsu_pkg::REG_ROW_LENGTH:  row_length_q  <= cfg_data_i[pngsu_pkg::LEN_W-1:0];
        pngsu_pkg::REG_PIXEL_BYTES: pixel_bytes_q <= cfg_data_i[pngsu_pkg::PB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q  <= 1'b1;
      first_row_q <= 1'b1;
      err_hold_q  <= 1'b0;
      col_cnt_q   <= '0;
      kind_q      <= pngsu_pkg::FILT_NONE;
      stage_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        awaiting_q  <= awaiting_d;
        first_row_q <= first_row_d;
        err_hold_q  <= err_hold_d;
        col_cnt_q   <= col_cnt_d;
        kind_q      <= kind_d;
        stage_vld_q <= res_err || res_data;
      end else if (s1_take_i) begin
        stage_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      stage_q.err       <= res_err;
      stage_q.fbyte     <= in_i.data.stream_byte;
      stage_q.col       <= col;
      stage_q.quo       <= prod[pngsu_pkg::DIV_K +: pngsu_pkg::ROW_AW];
      stage_q.kind      <= kind_q;
      stage_q.first_row <= first_row_q;
      stage_q.last      <= last;
      stage_q.bpp       <= bpp;
    end
  end

  // The byte above is fetched as the data byte is transferred in.
  assign rd_o.en     = acc && res_data;
  assign rd_o.addr   = col;
  assign stage_vld_o = stage_vld_q;
  assign stage_o     = stage_q;

endmodule

### rtl/pngsu_recon.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter reconstruction
// Predictor, left and upper-left history, and the output register.
// ----------------------------------------------------------------------------
module pngsu_recon (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               stage_vld_i,
  input  pngsu_pkg::stage_t  stage_i,
  input  logic [7:0]         up_i,
  output logic               s1_take_o,
  output pngsu_pkg::mem_wr_t wr_o,
  pngsu_out_if.source        out_o
);

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [9:0] pa, pb, pc, s, t;
    pa = (b >= c) ? 10'(b - c) : 10'(c - b);
    pb = (a >= c) ? 10'(a - c) : 10'(c - a);
    s  = {2'b00, a} + {2'b00, b};
    t  = {1'b0, c, 1'b0};
    pc = (s >= t) ? (s - t) : (t - s);
    if (pa <= pb && pa <= pc) begin
      return a;
    end
    return (pb <= pc) ? b : c;
  endfunction

  logic [7:0]                    left_hist_q   [pngsu_pkg::MAX_PIXEL_BYTES];
  logic [7:0]                    upleft_hist_q [pngsu_pkg::MAX_PIXEL_BYTES];
  logic                          out_vld_q;
  pngsu_pkg::out_item_t          out_q;

  logic                          adv;
  logic [pngsu_pkg::ROW_AW-1:0]  slot_full;
  logic [pngsu_pkg::HIST_AW-1:0] slot, left_idx;
  logic [pngsu_pkg::SLOT_W-1:0]  slot_w, bpp_w, li_w;
  logic                          have_left;
  logic [7:0]                    left, up, upleft, pred, value;
  logic [8:0]                    sum;

  assign s1_take_o = !out_vld_q || out_o.ready;
  assign adv       = stage_vld_i && s1_take_o;

  always_comb begin
    // Column modulo the history depth, from the quotient found up front.
    slot_full = stage_i.col - stage_i.quo * pngsu_pkg::ROW_AW'(pngsu_pkg::MAX_PIXEL_BYTES);
    slot      = slot_full[pngsu_pkg::HIST_AW-1:0];

    slot_w = pngsu_pkg::SLOT_W'(slot);
    bpp_w  = pngsu_pkg::SLOT_W'(stage_i.bpp);
    if (slot_w >= bpp_w) begin
      li_w = slot_w - bpp_w;
    end else begin
      li_w = slot_w + pngsu_pkg::SLOT_W'(pngsu_pkg::MAX_PIXEL_BYTES) - bpp_w;
    end
    left_idx = li_w[pngsu_pkg::HIST_AW-1:0];

    have_left = stage_i.col >= pngsu_pkg::ROW_AW'(stage_i.bpp);
    left      = have_left ? left_hist_q[left_idx] : 8'd0;
    up        = stage_i.first_row ? 8'd0 : up_i;
    upleft    = (have_left && !stage_i.first_row) ? upleft_hist_q[left_idx] : 8'd0;
    sum       = {1'b0, left} + {1'b0, up};

    case (stage_i.kind)
      pngsu_pkg::FILT_SUB:   pred = left;
      pngsu_pkg::FILT_UP:    pred = up;
      pngsu_pkg::FILT_AVG:   pred = sum[8:1];
      pngsu_pkg::FILT_PAETH: pred = paeth(left, up, upleft);
      default:               pred = 8'd0;
    endcase
    value = stage_i.fbyte + pred;
  end

  always_ff @(posedge clk_i) begin
    if (adv && !stage_i.err) begin
      left_hist_q[slot]   <= value;
      upleft_hist_q[slot] <= up;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (stage_i.err) begin
        out_q.pixel_byte <= 8'd0;
        out_q.row_end    <= 1'b0;
        out_q.bad_filter <= 1'b1;
      end else begin
        out_q.pixel_byte <= value;
        out_q.row_end    <= stage_i.last;
        out_q.bad_filter <= 1'b0;
      end
    end
  end

  assign wr_o.en      = adv && !stage_i.err;
  assign wr_o.addr    = stage_i.col;
  assign wr_o.data    = value;
  assign out_o.valid  = out_vld_q;
  assign out_o.data   = out_q;

endmodule

### rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Reconstructs None, Sub, Up, Average and Paeth filtered scanlines.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle while the output is not stalled:
// a valid filter byte is absorbed with no result, and each data byte passes
// through the stage register into the output register, so a fresh byte can be
// accepted while earlier results are still on their way out. The rate is held
// by the prior row memory, whose single registered read port fetches the byte
// above as the data byte is taken in, one stage ahead of the predictor. The
// memory holds no reset contents and needs no clearing pass, so the block is
// ready as soon as reset is released. Row length and pixel size must only be
// written while no results are outstanding.
`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pngsu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pngsu_pkg::CFG_W-1:0]     cfg_data_i,
  pngsu_in_if.sink                        in_i,
  pngsu_out_if.source                     out_o
);

  logic               stage_vld;
  pngsu_pkg::stage_t  stage;
  pngsu_pkg::mem_rd_t rd_req;
  pngsu_pkg::mem_wr_t wr_req;
  logic [7:0]         up_byte;
  logic               s1_take;

  pngsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .s1_take_i   (s1_take),
    .stage_vld_o (stage_vld),
    .stage_o     (stage),
    .rd_o        (rd_req)
  );

  pngsu_row_mem u_row_mem (
    .clk_i   (clk_i),
    .wr_i    (wr_req),
    .rd_i    (rd_req),
    .rdata_o (up_byte)
  );

  pngsu_recon u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_vld_i (stage_vld),
    .stage_i     (stage),
    .up_i        (up_byte),
    .s1_take_o   (s1_take),
    .wr_o        (wr_req),
    .out_o       (out_o)
  );

  // A full stage behind a stalled output must hold off the input.
  `PNGSU_ASSERT(a_block_when_full, clk_i, rst_ni, (stage_vld && out_o.valid && !out_o.ready) |-> !in_i.ready)
  // Every row memory fetch belongs to an item that lands in the stage register.
  `PNGSU_ASSERT_NEXT(a_fetch_fills_stage, clk_i, rst_ni, rd_req.en, stage_vld)
  // An item leaving the stage is offered on the output in the next cycle.
  `PNGSU_ASSERT_NEXT(a_stage_to_output, clk_i, rst_ni, stage_vld && s1_take, out_o.valid)

endmodule
